// ===== src/gmd_pkg.sv =====
package gmd_pkg;

  // Derivative width used when the top level is not overridden
  localparam int GRAD_WIDTH_DEF = 16;

  // Result field width and its saturation value
  localparam int          OUT_W   = 16;
  localparam logic [15:0] OUT_MAX = 16'hFFFF;

  // Threshold register
  localparam int          THRESH_W     = 16;
  localparam logic [15:0] THRESH_RESET = 16'd120;

  // Quantized edge direction
  typedef enum logic [1:0] {
    DIR_0   = 2'd0,
    DIR_45  = 2'd1,
    DIR_90  = 2'd2,
    DIR_M45 = 2'd3
  } dir_t;

endpackage

// ===== src/gradient_magnitude_direction_top.sv =====
// Gradient magnitude and direction, one pixel per clock.
//
// Input: drive in_grad_x / in_grad_y (two's complement derivatives) and pulse
// start; a transaction is taken at every rising edge with start high and busy
// low. busy never rises: the pipeline takes a new pixel in every cycle.
// Output: out_valid is high for exactly one cycle per pixel, carrying
// out_magnitude (floor of sqrt(gx^2+gy^2), saturated to 16 bits),
// out_kept_magnitude (zero below the threshold) and out_direction
// (0 = 0 deg, 1 = 45 deg, 2 = 90 deg, 3 = -45 deg). Results leave in order.
// Throughput is one pixel per cycle. The square-root pipeline resolves one
// root bit per stage (GRAD_WIDTH stages) behind three stages of absolute
// value, squaring and summing.
// The receiver cannot stall; results must be captured when out_valid is high.
// Configuration: cfg_wr_en with cfg_wr_data writes the 16-bit edge threshold
// (reset value 120). Write it only while no pixel is in flight.
// Reset (rst_n low, synchronous) empties the pipeline and restores the
// threshold; pixels in flight are dropped.
module gradient_magnitude_direction_top #(
  parameter int GRAD_WIDTH = gmd_pkg::GRAD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [GRAD_WIDTH-1:0]  in_grad_x,
  input  logic signed [GRAD_WIDTH-1:0]  in_grad_y,
  input  logic                          cfg_wr_en,
  input  logic [gmd_pkg::THRESH_W-1:0]  cfg_wr_data,
  output logic                          out_valid,
  output logic [gmd_pkg::OUT_W-1:0]     out_magnitude,
  output logic [gmd_pkg::OUT_W-1:0]     out_kept_magnitude,
  output logic [1:0]                    out_direction
);
  import gmd_pkg::*;

  localparam int W    = GRAD_WIDTH;
  localparam int SQW  = 2 * W;
  localparam int SSW  = 2 * W + 2;
  localparam int RW   = W + 2;
  localparam int XW   = (W > OUT_W) ? W : OUT_W;

  // Threshold register
  logic [THRESH_W-1:0] thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_wr_en) begin
      thresh_r <= cfg_wr_data;
    end
  end

  assign busy = 1'b0;

  // Stage 1: absolute values and signs
  logic           s1_vld_r;
  logic [W-1:0]   s1_ax_r, s1_ay_r;
  logic           s1_same_r;
  logic [W-1:0]   s1_ax_nxt, s1_ay_nxt;

  always_comb begin
    s1_ax_nxt = in_grad_x[W-1] ? (~in_grad_x + 1'b1) : in_grad_x;
    s1_ay_nxt = in_grad_y[W-1] ? (~in_grad_y + 1'b1) : in_grad_y;
  end

  // Stage 2: squares, sum and difference of the magnitudes
  logic           s2_vld_r;
  logic [SQW-1:0] s2_a2_r, s2_b2_r;
  logic [W:0]     s2_sum_r;
  logic [W-1:0]   s2_diff_r;
  logic           s2_bgt_r, s2_azero_r, s2_same_r;

  // Stage 3: radicand and squares for the sector bounds
  logic           s3_vld_r;
  logic [SQW-1:0] s3_n_r, s3_a2_r, s3_diffsq_r;
  logic [SSW-1:0] s3_sumsq_r;
  logic           s3_bgt_r, s3_azero_r, s3_same_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_ax_r   <= s1_ax_nxt;
    s1_ay_r   <= s1_ay_nxt;
    s1_same_r <= in_grad_x[W-1] == in_grad_y[W-1];

    s2_a2_r    <= s1_ax_r * s1_ax_r;
    s2_b2_r    <= s1_ay_r * s1_ay_r;
    s2_sum_r   <= {1'b0, s1_ax_r} + {1'b0, s1_ay_r};
    s2_diff_r  <= s1_ay_r - s1_ax_r;
    s2_bgt_r   <= s1_ay_r > s1_ax_r;
    s2_azero_r <= s1_ax_r == '0;
    s2_same_r  <= s1_same_r;

    s3_n_r      <= s2_a2_r + s2_b2_r;
    s3_a2_r     <= s2_a2_r;
    s3_sumsq_r  <= s2_sum_r * s2_sum_r;
    s3_diffsq_r <= s2_diff_r * s2_diff_r;
    s3_bgt_r    <= s2_bgt_r;
    s3_azero_r  <= s2_azero_r;
    s3_same_r   <= s2_same_r;
  end

  // Sector decision from tan(22.5) and tan(67.5) bounds compared as squares
  logic [SQW:0] twoa2;
  logic         below_lo, above_hi;
  dir_t         dir_nxt;

  always_comb begin
    twoa2    = {s3_a2_r, 1'b0};
    below_lo = s3_sumsq_r < {1'b0, twoa2};
    above_hi = s3_bgt_r && ({1'b0, s3_diffsq_r} > twoa2);
    priority if (s3_azero_r) begin
      dir_nxt = DIR_90;
    end else if (below_lo) begin
      dir_nxt = DIR_0;
    end else if (above_hi) begin
      dir_nxt = DIR_90;
    end else if (s3_same_r) begin
      dir_nxt = DIR_45;
    end else begin
      dir_nxt = DIR_M45;
    end
  end

  // Square-root pipeline: one root bit per stage, restoring method
  logic           sq_vld_r  [W];
  logic [RW-1:0]  sq_rem_r  [W];
  logic [W-1:0]   sq_q_r    [W];
  logic [SQW-1:0] sq_n_r    [W];
  dir_t           sq_dir_r  [W];

  for (genvar k = 0; k < W; k++) begin : g_sqrt
    logic           vld_in;
    logic [RW-1:0]  rem_in;
    logic [W-1:0]   q_in;
    logic [SQW-1:0] n_in;
    dir_t           dir_in;
    logic [RW-1:0]  rem_sh, trial, rem_nxt;
    logic           take;
    logic [W-1:0]   q_nxt;

    if (k == 0) begin : g_first
      assign vld_in = s3_vld_r;
      assign rem_in = '0;
      assign q_in   = '0;
      assign n_in   = s3_n_r;
      assign dir_in = dir_nxt;
    end else begin : g_next
      assign vld_in = sq_vld_r[k-1];
      assign rem_in = sq_rem_r[k-1];
      assign q_in   = sq_q_r[k-1];
      assign n_in   = sq_n_r[k-1];
      assign dir_in = sq_dir_r[k-1];
    end

    // Bring down two radicand bits and try the next root bit
    always_comb begin
      rem_sh  = {rem_in[W-1:0], n_in[SQW-1 -: 2]};
      trial   = {q_in, 2'b01};
      take    = rem_sh >= trial;
      rem_nxt = take ? (rem_sh - trial) : rem_sh;
      q_nxt   = {q_in[W-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k] <= 1'b0;
      end else begin
        sq_vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      sq_rem_r[k] <= rem_nxt;
      sq_q_r[k]   <= q_nxt;
      sq_n_r[k]   <= {n_in[SQW-3:0], 2'b00};
      sq_dir_r[k] <= dir_in;
    end
  end

  // Output stage: saturate, apply the threshold to the true magnitude
  logic [XW-1:0]    mag_x, thr_x;
  logic [OUT_W-1:0] mag_sat, kept_nxt;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_mag_r, out_kept_r;
  dir_t             out_dir_r;

  always_comb begin
    mag_x    = XW'(sq_q_r[W-1]);
    thr_x    = XW'(thresh_r);
    mag_sat  = (mag_x > XW'(OUT_MAX)) ? OUT_MAX : mag_x[OUT_W-1:0];
    kept_nxt = (mag_x < thr_x) ? '0 : mag_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sq_vld_r[W-1];
    end
  end

  always_ff @(posedge clk) begin
    out_mag_r  <= mag_sat;
    out_kept_r <= kept_nxt;
    out_dir_r  <= sq_dir_r[W-1];
  end

  assign out_valid          = out_valid_r;
  assign out_magnitude      = out_mag_r;
  assign out_kept_magnitude = out_kept_r;
  assign out_direction      = out_dir_r;

endmodule

// ===== test/gmd_checker.sv =====
module gmd_checker #(
  parameter int GW = gmd_pkg::GRAD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic signed [GW-1:0]         grad_x,
  input  logic signed [GW-1:0]         grad_y,
  input  logic                         cfg_wr_en,
  input  logic [gmd_pkg::THRESH_W-1:0] cfg_wr_data,
  input  logic                         out_valid,
  input  logic [gmd_pkg::OUT_W-1:0]    out_magnitude,
  input  logic [gmd_pkg::OUT_W-1:0]    out_kept_magnitude,
  input  logic [1:0]                   out_direction,
  output int                           fails,
  output int                           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import gmd_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] magnitude;
    logic [OUT_W-1:0] kept;
    dir_t             direction;
  } pixel_result_t;

  pixel_result_t       pixel_results_q[$];
  pixel_result_t       oldest;
  logic [THRESH_W-1:0] threshold;

  // Floor of the square root, one root bit per iteration
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned step;
    root = 0;
    step = 64'h1 << 62;
    while (step > n) step = step >> 2;
    while (step != 0) begin
      if (n >= root + step) begin
        n    = n - (root + step);
        root = (root >> 1) + step;
      end else begin
        root = root >> 1;
      end
      step = step >> 2;
    end
    return root;
  endfunction

  // Magnitude, thresholded magnitude and quantized direction of one pixel
  function automatic pixel_result_t predict_gradient(logic signed [GW-1:0] gx,
                                                     logic signed [GW-1:0] gy,
                                                     logic [THRESH_W-1:0] thr);
    longint          sx;
    longint          sy;
    longint unsigned a;
    longint unsigned b;
    longint unsigned mag;
    longint unsigned kept;
    pixel_result_t   res;
    sx = gx;
    sy = gy;
    a = (sx < 0) ? -sx : sx;
    b = (sy < 0) ? -sy : sy;
    mag  = int_sqrt(a * a + b * b);
    kept = (mag < thr) ? 0 : mag;
    res.magnitude = (mag > OUT_MAX) ? OUT_MAX : mag[OUT_W-1:0];
    res.kept      = (kept > OUT_MAX) ? OUT_MAX : kept[OUT_W-1:0];
    // Compare against tan(22.5) and tan(67.5) through exact squares
    if (a == 0)
      res.direction = DIR_90;
    else if ((a + b) * (a + b) < 2 * a * a)
      res.direction = DIR_0;
    else if (b > a && (b - a) * (b - a) > 2 * a * a)
      res.direction = DIR_90;
    else if ((sx < 0) == (sy < 0))
      res.direction = DIR_45;
    else
      res.direction = DIR_M45;
    return res;
  endfunction

  // Track the threshold, queue predictions and compare each result transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      threshold = THRESH_RESET;
      pixel_results_q.delete();
    end else begin
      if ($isunknown(out_valid)) begin
        $error("out_valid is unknown");
        fails++;
      end else if (out_valid) begin
        if (pixel_results_q.size() == 0) begin
          $error("result transaction with no pixel outstanding");
          fails++;
        end else begin
          oldest = pixel_results_q.pop_front();
          if (out_magnitude !== oldest.magnitude) begin
            $error("magnitude: expected %0d, got %0d", oldest.magnitude, out_magnitude);
            fails++;
          end
          if (out_kept_magnitude !== oldest.kept) begin
            $error("kept_magnitude: expected %0d, got %0d",
                   oldest.kept, out_kept_magnitude);
            fails++;
          end
          if (out_direction !== oldest.direction) begin
            $error("direction: expected %0d, got %0d", oldest.direction, out_direction);
            fails++;
          end
        end
      end
      if (start && !busy)
        pixel_results_q.push_back(predict_gradient(grad_x, grad_y, threshold));
      if (cfg_wr_en)
        threshold = cfg_wr_data;
    end
    pending = pixel_results_q.size();
  end

endmodule

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gmd_pkg::*;

  localparam int GW           = GRAD_WIDTH_DEF;
  localparam int LATENCY      = GW + 3;
  localparam int N_DIRECTED   = 24;
  localparam int N_PHASES     = 5;
  localparam int PHASE_PIXELS = 360;
  localparam int BURSTY       = -1;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 start       = 1'b0;
  logic signed [GW-1:0] in_grad_x   = '0;
  logic signed [GW-1:0] in_grad_y   = '0;
  logic                 cfg_wr_en   = 1'b0;
  logic [THRESH_W-1:0]  cfg_wr_data = '0;
  logic                 busy;
  logic                 out_valid;
  logic [OUT_W-1:0]     out_magnitude;
  logic [OUT_W-1:0]     out_kept_magnitude;
  logic [1:0]           out_direction;
  int                   fails;
  int                   pending;
  int                   cur_threshold = THRESH_RESET;

  // Extremes, sector edges and threshold edges
  int directed_gx[N_DIRECTED] = '{0, 0, 0, 0, 5, -5, -32768, 32767, -32768, -32768,
                                  32767, 1, 1, -1, -1, 1000, 1000, -1000, -1000,
                                  119, 120, 0, 72, -84};
  int directed_gy[N_DIRECTED] = '{0, 5, -32768, 32767, 0, 0, 0, 32767, -32768, 32767,
                                  -32768, 1, -1, 1, -1, 414, 415, 2414, 2415,
                                  0, 0, -121, 96, -85};

  int phase_threshold[N_PHASES] = '{THRESH_RESET, 0, 65535, 0, 1};
  int phase_idle[N_PHASES]      = '{0, 81, 19, BURSTY, 19};

  always #5 clk = ~clk;

  gradient_magnitude_direction_top #(.GRAD_WIDTH(GW)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_grad_x          (in_grad_x),
    .in_grad_y          (in_grad_y),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .out_valid          (out_valid),
    .out_magnitude      (out_magnitude),
    .out_kept_magnitude (out_kept_magnitude),
    .out_direction      (out_direction)
  );

  gmd_checker #(.GW(GW)) u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .grad_x             (in_grad_x),
    .grad_y             (in_grad_y),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .out_valid          (out_valid),
    .out_magnitude      (out_magnitude),
    .out_kept_magnitude (out_kept_magnitude),
    .out_direction      (out_direction),
    .fails              (fails),
    .pending            (pending)
  );

  // Present one pixel and hold it until the transaction is taken
  task automatic send_pixel(input int gx, input int gy);
    @(negedge clk);
    in_grad_x <= GW'(gx);
    in_grad_y <= GW'(gy);
    start     <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Drop start for the given number of cycles
  task automatic hold_idle(input int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Stop sending until every outstanding pixel has returned
  task automatic drain_pipeline();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_threshold(input int value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= THRESH_W'(value);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cur_threshold = value;
  endtask

  // Mix full-range, small, sector-edge, axis, extreme and threshold-edge pixels
  task automatic random_pixel(output int gx, output int gy);
    int     mode;
    int     a;
    longint b;
    int     extremes[6];
    extremes = '{-32768, -32767, -1, 0, 1, 32767};
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1, 2: begin
        gx = $signed(16'($urandom));
        gy = $signed(16'($urandom));
      end
      3, 4: begin
        gx = $urandom_range(0, 600) - 300;
        gy = $urandom_range(0, 600) - 300;
      end
      5, 6: begin
        a = $urandom_range(1, 13000);
        if ($urandom_range(0, 1))
          b = (longint'(a) * 41421) / 100000;
        else
          b = (longint'(a) * 241421) / 100000;
        b = b + $urandom_range(0, 6) - 3;
        if (b < 0) b = 0;
        if (b > 32767) b = 32767;
        gx = $urandom_range(0, 1) ? -a : a;
        gy = $urandom_range(0, 1) ? -int'(b) : int'(b);
        if ($urandom_range(0, 1)) begin
          a  = gx;
          gx = gy;
          gy = a;
        end
      end
      7: begin
        gx = $signed(16'($urandom));
        gy = 0;
        if ($urandom_range(0, 1)) begin
          gy = gx;
          gx = 0;
        end
      end
      8: begin
        gx = extremes[$urandom_range(0, 5)];
        gy = extremes[$urandom_range(0, 5)];
      end
      default: begin
        a = cur_threshold + $urandom_range(0, 4) - 2;
        if (a < 0) a = 0;
        if (a > 32767) a = 32767;
        gx = $urandom_range(0, 1) ? -a : a;
        gy = $urandom_range(0, 3) - 1;
      end
    endcase
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    int gx;
    int gy;
    int pct;
    int gap;
    int thr;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++)
      send_pixel(directed_gx[i], directed_gy[i]);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        drain_pipeline();
        thr = (ph == 3) ? $urandom_range(2, 3000) : phase_threshold[ph];
        write_threshold(thr);
      end
      for (int k = 0; k < PHASE_PIXELS; k++) begin
        pct = phase_idle[ph];
        if (pct == BURSTY)
          pct = ((k / 50) % 2) ? 81 : 0;
        gap = 0;
        while ($urandom_range(0, 99) < pct) gap++;
        if (gap > 0)
          hold_idle(gap);
        // Pause now and then until the pipeline is empty
        if ($urandom_range(0, 299) == 0)
          drain_pipeline();
        random_pixel(gx, gy);
        send_pixel(gx, gy);
      end
    end

    drain_pipeline();
    if (fails == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Bound the run
  initial begin : watchdog
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
